// ===== design/pba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, register indexes and constants of the pixel brightness block.
// ----------------------------------------------------------------------------
package pba_pkg;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  localparam int CFG_IDX_W = 1;
  localparam int PCT_W     = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_PERCENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DARKEN_MODE    = 1'd1;

  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS   = 4;

  typedef struct packed {
    logic [13:0] rem;
    logic [15:0] nq;
    logic [13:0] den;
  } div_stage_t;

  localparam logic [15:0] HUE_SECTOR = 16'd6000;
  localparam logic [15:0] HUE_TURN   = 16'd36000;
  localparam logic [20:0] FRAC_SCALE = 21'd1530000;
  localparam logic [19:0] FRAC_RECIP = 20'd718635;

  // Quotient 10000 / p for percents below one hundred.
  localparam logic [13:0] RECIP_PCT [128] = '{
    14'd0,    14'd10000, 14'd5000, 14'd3333, 14'd2500, 14'd2000, 14'd1666, 14'd1428,
    14'd1250, 14'd1111,  14'd1000, 14'd909,  14'd833,  14'd769,  14'd714,  14'd666,
    14'd625,  14'd588,   14'd555,  14'd526,  14'd500,  14'd476,  14'd454,  14'd434,
    14'd416,  14'd400,   14'd384,  14'd370,  14'd357,  14'd344,  14'd333,  14'd322,
    14'd312,  14'd303,   14'd294,  14'd285,  14'd277,  14'd270,  14'd263,  14'd256,
    14'd250,  14'd243,   14'd238,  14'd232,  14'd227,  14'd222,  14'd217,  14'd212,
    14'd208,  14'd204,   14'd200,  14'd196,  14'd192,  14'd188,  14'd185,  14'd181,
    14'd178,  14'd175,   14'd172,  14'd169,  14'd166,  14'd163,  14'd161,  14'd158,
    14'd156,  14'd153,   14'd151,  14'd149,  14'd147,  14'd144,  14'd142,  14'd140,
    14'd138,  14'd136,   14'd135,  14'd133,  14'd131,  14'd129,  14'd128,  14'd126,
    14'd125,  14'd123,   14'd121,  14'd120,  14'd119,  14'd117,  14'd116,  14'd114,
    14'd113,  14'd112,   14'd111,  14'd109,  14'd108,  14'd107,  14'd106,  14'd105,
    14'd104,  14'd103,   14'd102,  14'd101,  14'd0,    14'd0,    14'd0,    14'd0,
    14'd0,    14'd0,     14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,
    14'd0,    14'd0,     14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,
    14'd0,    14'd0,     14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0
  };

endpackage
`default_nettype wire

// ===== design/pba_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_div
// Pipelined restoring divider: 24-bit dividend, 14-bit divisor, 16-bit
// quotient, four quotient bits per stage.
// ----------------------------------------------------------------------------
module pba_div (
  input  logic        clk,
  input  logic        en,
  input  logic [23:0] num,
  input  logic [13:0] den,
  output logic [15:0] quo
);

  pba_pkg::div_stage_t stg_r   [pba_pkg::DIV_STAGES];
  pba_pkg::div_stage_t stg_nxt [pba_pkg::DIV_STAGES];
  pba_pkg::div_stage_t init;

  function automatic pba_pkg::div_stage_t div_step(pba_pkg::div_stage_t x);
    pba_pkg::div_stage_t y;
    logic [14:0]         t;
    y = x;
    for (int j = 0; j < pba_pkg::DIV_BITS; j++) begin
      t = {y.rem, y.nq[15]};
      if (t >= {1'b0, y.den}) begin
        t    = t - {1'b0, y.den};
        y.nq = {y.nq[14:0], 1'b1};
      end else begin
        y.nq = {y.nq[14:0], 1'b0};
      end
      y.rem = t[13:0];
    end
    return y;
  endfunction

  always_comb begin
    init.rem   = {6'd0, num[23:16]};
    init.nq    = num[15:0];
    init.den   = den;
    stg_nxt[0] = div_step(init);
    for (int k = 1; k < pba_pkg::DIV_STAGES; k++) begin
      stg_nxt[k] = div_step(stg_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < pba_pkg::DIV_STAGES; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign quo = stg_r[pba_pkg::DIV_STAGES-1].nq;

endmodule
`default_nettype wire

// ===== design/pixel_brightness_adjust.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_brightness_adjust
// Lightens or darkens RGBA pixels through an integer HSV conversion.
// ----------------------------------------------------------------------------
// One pixel can be taken every clock unless a waiting result is stalled; each
// pixel passes from its input transfer to its result through the pipeline: the
// color analysis, the three four-stage dividers for hue, saturation and value,
// and the multiply and correct stages of the conversion back to RGB. The whole
// pipeline holds while a waiting result is stalled. Write configuration only
// when no pixel is in flight.
module pixel_brightness_adjust (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pba_pkg::pix_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pba_pkg::pix_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pba_pkg::PCT_W-1:0]        cfg_data
);

  localparam int NSTG = 12;

  typedef struct packed {
    logic             pass;
    logic             dark;
    logic             gray;
    pba_pkg::pix_in_t pix;
  } side_t;

  logic                      en;
  logic [NSTG-1:0]           vld_r;
  logic [pba_pkg::PCT_W-1:0] pct_r;
  logic                      dark_r;

  // Stage 0
  pba_pkg::pix_in_t          pix0_r;
  logic                      pass0_r, dark0_r;
  logic [13:0]               pct0_r;
  logic [13:0]               pct_eff;
  logic                      dark_eff;

  // Stage 1
  side_t                     sd1_r;
  logic [7:0]                mx1_r, d1_r;
  logic [10:0]               m1_r;
  logic [13:0]               pct1_r;
  logic [7:0]                mx, mn, dd;
  logic [10:0]               m;

  // Stage 2
  side_t                     sd2_r;
  logic [23:0]               hnum2_r;
  logic [15:0]               snum2_r;
  logic [21:0]               vnum2_r;
  logic [13:0]               vden2_r;
  logic [7:0]                mx2_r, d2_r;

  // Divider stages
  side_t                     sdd_r [pba_pkg::DIV_STAGES];
  logic [15:0]               hq, sq, vq;

  // Stage 7
  pba_pkg::pix_in_t          pix7_r;
  logic                      pass7_r;
  logic [2:0]                i7_r;
  logic [12:0]               f7_r;
  logic [7:0]                s7_r, v7_r;
  logic [15:0]               h;
  logic [2:0]                isec;
  logic [15:0]               base;
  logic [7:0]                s_in, s_adj, v_adj;
  logic [15:0]               excess;

  // Stage 8
  pba_pkg::pix_in_t          pix8_r;
  logic                      pass8_r;
  logic [2:0]                i8_r;
  logic [7:0]                v8_r;
  logic [20:0]               sf8_r, st8_r;
  logic [15:0]               pn8_r;

  // Stage 9
  pba_pkg::pix_in_t          pix9_r;
  logic                      pass9_r;
  logic [2:0]                i9_r;
  logic [7:0]                v9_r, p9_r;
  logic [28:0]               xq9_r, xt9_r;
  logic [15:0]               psum;

  // Stage 10
  pba_pkg::pix_in_t          pix10_r;
  logic                      pass10_r;
  logic [2:0]                i10_r;
  logic [7:0]                v10_r, p10_r, qa10_r, ta10_r;
  logic [28:0]               xq10_r, xt10_r;
  logic [48:0]               prq, prt;

  // Stage 11
  pba_pkg::pix_in_t          pix11_r;
  logic                      pass11_r;
  logic [2:0]                i11_r;
  logic [7:0]                v11_r, p11_r, q11_r, t11_r;
  logic [28:0]               remq, remt;

  // Output
  logic                      out_valid_r;
  pba_pkg::pix_out_t         out_data_r, out_nxt;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r  <= 14'd100;
      dark_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pba_pkg::CFG_ADJUST_PERCENT: pct_r  <= cfg_data;
        pba_pkg::CFG_DARKEN_MODE:    dark_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NSTG-2:0], in_valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_comb begin
    if (pct_r < 14'd100) begin
      pct_eff  = pba_pkg::RECIP_PCT[pct_r[6:0]];
      dark_eff = !dark_r;
    end else begin
      pct_eff  = pct_r;
      dark_eff = dark_r;
    end
  end

  // Max, min and hue numerator.
  always_comb begin
    mx = pix0_r.in_red;
    mn = pix0_r.in_red;
    if (pix0_r.in_green > mx) mx = pix0_r.in_green;
    if (pix0_r.in_blue > mx)  mx = pix0_r.in_blue;
    if (pix0_r.in_green < mn) mn = pix0_r.in_green;
    if (pix0_r.in_blue < mn)  mn = pix0_r.in_blue;
    dd = mx - mn;
    if (pix0_r.in_red == mx) begin
      if (pix0_r.in_green >= pix0_r.in_blue) begin
        m = {3'd0, pix0_r.in_green} - {3'd0, pix0_r.in_blue};
      end else begin
        m = {3'd0, pix0_r.in_green} + {1'b0, dd, 2'b00} + {2'b00, dd, 1'b0}
            - {3'd0, pix0_r.in_blue};
      end
    end else if (pix0_r.in_green == mx) begin
      m = {2'b00, dd, 1'b0} + {3'd0, pix0_r.in_blue} - {3'd0, pix0_r.in_red};
    end else begin
      m = {1'b0, dd, 2'b00} + {3'd0, pix0_r.in_red} - {3'd0, pix0_r.in_green};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix0_r  <= in_data;
      pass0_r <= (pct_r == '0);
      pct0_r  <= pct_eff;
      dark0_r <= dark_eff;

      sd1_r.pass <= pass0_r;
      sd1_r.dark <= dark0_r;
      sd1_r.gray <= (dd == 8'd0);
      sd1_r.pix  <= pix0_r;
      mx1_r      <= mx;
      d1_r       <= dd;
      m1_r       <= m;
      pct1_r     <= pct0_r;

      sd2_r   <= sd1_r;
      hnum2_r <= 24'(m1_r * 13'd6000);
      snum2_r <= 16'(d1_r * 8'd255);
      if (sd1_r.dark) begin
        vnum2_r <= 22'(mx1_r * 7'd100);
        vden2_r <= pct1_r;
      end else begin
        vnum2_r <= 22'(pct1_r * mx1_r);
        vden2_r <= 14'd100;
      end
      mx2_r <= mx1_r;
      d2_r  <= d1_r;

      sdd_r[0] <= sd2_r;
      for (int k = 1; k < pba_pkg::DIV_STAGES; k++) begin
        sdd_r[k] <= sdd_r[k-1];
      end
    end
  end

  pba_div u_div_hue (
    .clk (clk),
    .en  (en),
    .num (hnum2_r),
    .den ({6'd0, d2_r}),
    .quo (hq)
  );

  pba_div u_div_sat (
    .clk (clk),
    .en  (en),
    .num ({8'd0, snum2_r}),
    .den ({6'd0, mx2_r}),
    .quo (sq)
  );

  pba_div u_div_val (
    .clk (clk),
    .en  (en),
    .num ({2'd0, vnum2_r}),
    .den (vden2_r),
    .quo (vq)
  );

  // Hue sector, value clamp and saturation give-back.
  always_comb begin
    h    = sdd_r[pba_pkg::DIV_STAGES-1].gray ? 16'd0 : hq;
    s_in = sdd_r[pba_pkg::DIV_STAGES-1].gray ? 8'd0 : sq[7:0];
    if (h >= pba_pkg::HUE_TURN) begin
      isec = 3'd0;
    end else begin
      isec = 3'(32'(h >= 16'd6000) + 32'(h >= 16'd12000) + 32'(h >= 16'd18000)
                + 32'(h >= 16'd24000) + 32'(h >= 16'd30000));
    end
    case (isec)
      3'd1:    base = 16'd6000;
      3'd2:    base = 16'd12000;
      3'd3:    base = 16'd18000;
      3'd4:    base = 16'd24000;
      3'd5:    base = 16'd30000;
      default: base = (h >= pba_pkg::HUE_TURN) ? h : 16'd0;
    endcase
    excess = vq - 16'd255;
    s_adj  = s_in;
    v_adj  = vq[7:0];
    if (!sdd_r[pba_pkg::DIV_STAGES-1].dark && vq > 16'd255) begin
      v_adj = 8'd255;
      s_adj = (excess >= {8'd0, s_in}) ? 8'd0 : s_in - excess[7:0];
    end
  end

  assign psum = pn8_r + 16'd1 + {8'd0, pn8_r[15:8]};
  assign prq  = 49'(xq9_r * pba_pkg::FRAC_RECIP);
  assign prt  = 49'(xt9_r * pba_pkg::FRAC_RECIP);
  assign remq = xq10_r - 29'(qa10_r * pba_pkg::FRAC_SCALE);
  assign remt = xt10_r - 29'(ta10_r * pba_pkg::FRAC_SCALE);

  always_ff @(posedge clk) begin
    if (en) begin
      pix7_r  <= sdd_r[pba_pkg::DIV_STAGES-1].pix;
      pass7_r <= sdd_r[pba_pkg::DIV_STAGES-1].pass;
      i7_r    <= isec;
      f7_r    <= 13'(h - base);
      s7_r    <= s_adj;
      v7_r    <= v_adj;

      pix8_r  <= pix7_r;
      pass8_r <= pass7_r;
      i8_r    <= i7_r;
      v8_r    <= v7_r;
      sf8_r   <= 21'(s7_r * f7_r);
      st8_r   <= 21'(s7_r * (13'd6000 - f7_r));
      pn8_r   <= 16'(v7_r * (8'd255 - s7_r));

      pix9_r  <= pix8_r;
      pass9_r <= pass8_r;
      i9_r    <= i8_r;
      v9_r    <= v8_r;
      p9_r    <= psum[15:8];
      xq9_r   <= 29'(v8_r * (pba_pkg::FRAC_SCALE - sf8_r));
      xt9_r   <= 29'(v8_r * (pba_pkg::FRAC_SCALE - st8_r));

      pix10_r  <= pix9_r;
      pass10_r <= pass9_r;
      i10_r    <= i9_r;
      v10_r    <= v9_r;
      p10_r    <= p9_r;
      xq10_r   <= xq9_r;
      xt10_r   <= xt9_r;
      qa10_r   <= prq[47:40];
      ta10_r   <= prt[47:40];

      pix11_r  <= pix10_r;
      pass11_r <= pass10_r;
      i11_r    <= i10_r;
      v11_r    <= v10_r;
      p11_r    <= p10_r;
      q11_r    <= qa10_r + 8'(remq >= {8'd0, pba_pkg::FRAC_SCALE});
      t11_r    <= ta10_r + 8'(remt >= {8'd0, pba_pkg::FRAC_SCALE});

      out_data_r <= out_nxt;
    end
  end

  always_comb begin
    out_nxt.out_alpha = pix11_r.in_alpha;
    case (i11_r)
      3'd0: begin
        out_nxt.out_red = v11_r; out_nxt.out_green = t11_r; out_nxt.out_blue = p11_r;
      end
      3'd1: begin
        out_nxt.out_red = q11_r; out_nxt.out_green = v11_r; out_nxt.out_blue = p11_r;
      end
      3'd2: begin
        out_nxt.out_red = p11_r; out_nxt.out_green = v11_r; out_nxt.out_blue = t11_r;
      end
      3'd3: begin
        out_nxt.out_red = p11_r; out_nxt.out_green = q11_r; out_nxt.out_blue = v11_r;
      end
      3'd4: begin
        out_nxt.out_red = t11_r; out_nxt.out_green = p11_r; out_nxt.out_blue = v11_r;
      end
      default: begin
        out_nxt.out_red = v11_r; out_nxt.out_green = p11_r; out_nxt.out_blue = q11_r;
      end
    endcase
    if (pass11_r) begin
      out_nxt.out_red   = pix11_r.in_red;
      out_nxt.out_green = pix11_r.in_green;
      out_nxt.out_blue  = pix11_r.in_blue;
    end
  end

`ifndef ASSERT_OFF
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid set right after reset.");
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("Input not stalled while result is held.");
  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("Pipeline moved during a stall.");
`endif

endmodule
`default_nettype wire
